/* rtl/sra_pkg.sv */
`timescale 1ns / 1ps
package sra_pkg;

	localparam int ADDR_W      = 24;
	localparam int BYTES_W     = 12;
	localparam int IDX_W       = 6;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_W       = 24;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 72;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CMD_W-1:0] CMD_SEEK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FILL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_DISC_SECTORS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISC_OPEN    = 1'd1;

	typedef enum logic [2:0] {
		OP_SEEK,
		OP_LOOKUP,
		OP_RELEASE,
		OP_FILL,
		OP_FLUSH,
		OP_NOP
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE      = 3'd0,
		ST_FILLED_OK = 3'd1,
		ST_FILLED_ER = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_CLOSED    = 3'd4,
		ST_PAST_END  = 3'd5
	} fill_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_COMMIT,
		B_FINISH
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [BYTES_W-1:0] bytes;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [BYTES_W-1:0] bytes;
		logic               failed;
	} slot_entry_t;

	typedef struct packed {
		logic               disc_open;
		logic [ADDR_W-1:0]  disc_sectors;
	} disc_cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  next_addr;
		logic               all_full;
		logic [ADDR_W-1:0]  fill_addr;
		fill_status_t       fill_status;
		logic               hit_failed;
		logic [BYTES_W-1:0] byte_count;
		logic [IDX_W-1:0]   slot_index;
		logic               hit;
	} result_t;

endpackage

/* rtl/sra_front.sv */
`timescale 1ns / 1ps
module sra_front import sra_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [IN_W-1:0]      s_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output logic                 push_valid,
	input  logic                 push_ready,
	output item_t                push_item,
	output disc_cfg_t            disc_cfg
);

	logic      valid_s1;
	item_t     item_s1;
	item_t     decoded;
	disc_cfg_t cfg_q;

	always_comb begin
		decoded.addr  = s_axis_tdata[26:3];
		decoded.bytes = s_axis_tdata[38:27];
		unique case (s_axis_tdata[2:0])
			CMD_SEEK:    decoded.op = OP_SEEK;
			CMD_LOOKUP:  decoded.op = OP_LOOKUP;
			CMD_RELEASE: decoded.op = OP_RELEASE;
			CMD_FILL:    decoded.op = OP_FILL;
			CMD_FLUSH:   decoded.op = OP_FLUSH;
			default:     decoded.op = OP_NOP;
		endcase
	end

	assign s_axis_tready = !valid_s1 || push_ready;
	assign push_valid    = valid_s1;
	assign push_item     = item_s1;
	assign disc_cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cfg_q    <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DISC_SECTORS: cfg_q.disc_sectors <= cfg_wdata[ADDR_W-1:0];
					REG_DISC_OPEN:    cfg_q.disc_open    <= cfg_wdata[0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= decoded;
		end
	end

endmodule

/* rtl/sra_queue.sv */
`timescale 1ns / 1ps
module sra_queue import sra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = entries[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/sra_back.sv */
`timescale 1ns / 1ps
module sra_back import sra_pkg::*; #(
	parameter int SLOTS        = 8,
	parameter int SECTOR_BYTES = 2352
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  item_t            pop_item,
	input  disc_cfg_t        disc_cfg,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int PW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0]      SLOTS_C = CW'(SLOTS);
	localparam logic [CW-1:0]      LAST_C  = CW'(SLOTS - 1);
	localparam logic [PW:0]        SLOTS_W = (PW+1)'(SLOTS);
	localparam logic [PW-1:0]      TOP_IDX = PW'(SLOTS - 1);
	localparam logic [BYTES_W-1:0] CAP     = BYTES_W'(SECTOR_BYTES);

	back_state_t state_q, state_d;

	slot_entry_t        slot_mem [SLOTS];
	slot_entry_t        rd_s1;
	logic [PW-1:0]      k_s1;
	logic               chk_s1;
	logic               last_s1;

	item_t              cur_q;
	logic [CW-1:0]      cnt_q;
	logic [SLOTS-1:0]   valid_q;
	logic [PW-1:0]      wp_q;
	logic [ADDR_W-1:0]  nf_q;
	logic               found_q;
	logic [PW-1:0]      slot_q;

	logic               hit_q;
	logic [PW-1:0]      idx_q;
	logic [BYTES_W-1:0] count_q;
	logic               failed_q;
	fill_status_t       status_q;
	logic [ADDR_W-1:0]  faddr_q;

	result_t            out_q;
	logic               out_valid_q;

	logic [PW-1:0]      base;
	logic [PW:0]        sum_w;
	logic [PW-1:0]      k;
	logic               v_k;
	logic               is_match;
	logic               scan_done;
	logic               issue;
	logic               release_clr;
	logic               out_free;
	logic               fill_ok;
	logic               mem_we;
	logic               take;

	assign base  = (cur_q.op == OP_FILL) ? wp_q : '0;
	assign sum_w = (PW+1)'(base) + (PW+1)'(cnt_q);
	assign k     = (sum_w >= SLOTS_W) ? PW'(sum_w - SLOTS_W) : PW'(sum_w);
	assign v_k   = valid_q[k_s1];

	assign is_match = chk_s1 && (((cur_q.op == OP_LOOKUP) && v_k && (rd_s1.addr == cur_q.addr))
		|| ((cur_q.op == OP_FILL) && !v_k));
	assign scan_done   = chk_s1 && (is_match || last_s1);
	assign issue       = (state_q == B_SCAN) && (cnt_q != SLOTS_C) && !scan_done;
	assign release_clr = (state_q == B_SCAN) && chk_s1 && (cur_q.op == OP_RELEASE) && v_k
		&& (rd_s1.addr < cur_q.addr);
	assign out_free    = !out_valid_q || m_axis_tready;
	assign fill_ok     = found_q && disc_cfg.disc_open && (nf_q < disc_cfg.disc_sectors);
	assign take        = pop_valid && pop_ready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		mem_we    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					unique case (pop_item.op)
						OP_LOOKUP, OP_RELEASE, OP_FILL: state_d = B_SCAN;
						OP_SEEK, OP_FLUSH:              state_d = B_COMMIT;
						default:                        state_d = B_FINISH;
					endcase
				end
			end
			B_SCAN: begin
				if (scan_done) begin
					state_d = (cur_q.op == OP_FILL) ? B_COMMIT : B_FINISH;
				end
			end
			B_COMMIT: begin
				mem_we  = (cur_q.op == OP_FILL) && fill_ok;
				state_d = B_FINISH;
			end
			B_FINISH: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			wp_q        <= '0;
			nf_q        <= '0;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (release_clr) begin
				valid_q[k_s1] <= 1'b0;
			end
			if (take) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if ((state_q == B_SCAN) && is_match && (cur_q.op == OP_FILL)) begin
				found_q <= 1'b1;
			end
			if (state_q == B_COMMIT) begin
				if ((cur_q.op == OP_SEEK) || (cur_q.op == OP_FLUSH)) begin
					valid_q <= '0;
					wp_q    <= '0;
				end
				if (cur_q.op == OP_SEEK) begin
					nf_q <= cur_q.addr;
				end
				if (mem_we) begin
					valid_q[slot_q] <= 1'b1;
					wp_q            <= (slot_q == TOP_IDX) ? '0 : slot_q + 1'b1;
					nf_q            <= nf_q + 1'b1;
				end
			end
			if ((state_q == B_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= k;
		last_s1 <= (cnt_q == LAST_C);
		if (take) begin
			cur_q    <= pop_item;
			hit_q    <= 1'b0;
			idx_q    <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
			status_q <= ST_NONE;
			faddr_q  <= '0;
		end
		if ((state_q == B_SCAN) && is_match) begin
			if (cur_q.op == OP_LOOKUP) begin
				hit_q    <= 1'b1;
				idx_q    <= k_s1;
				count_q  <= (rd_s1.bytes > CAP) ? CAP : rd_s1.bytes;
				failed_q <= rd_s1.failed;
			end else begin
				slot_q <= k_s1;
			end
		end
		if ((state_q == B_COMMIT) && (cur_q.op == OP_FILL)) begin
			priority if (!found_q) begin
				status_q <= ST_NO_SLOT;
			end else if (!disc_cfg.disc_open) begin
				status_q <= ST_CLOSED;
			end else if (nf_q >= disc_cfg.disc_sectors) begin
				status_q <= ST_PAST_END;
			end else begin
				idx_q    <= slot_q;
				faddr_q  <= nf_q;
				status_q <= (cur_q.bytes == '0) ? ST_FILLED_ER : ST_FILLED_OK;
			end
		end
		if ((state_q == B_FINISH) && out_free) begin
			out_q.hit         <= hit_q;
			out_q.slot_index  <= IDX_W'(idx_q);
			out_q.byte_count  <= count_q;
			out_q.hit_failed  <= failed_q;
			out_q.fill_status <= status_q;
			out_q.fill_addr   <= faddr_q;
			out_q.all_full    <= &valid_q;
			out_q.next_addr   <= nf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[slot_q] <= '{addr: nf_q, bytes: cur_q.bytes, failed: (cur_q.bytes == '0)};
		end
		rd_s1 <= slot_mem[k];
	end

endmodule

/* rtl/sector_readahead_slot_manager_top.sv */
`timescale 1ns / 1ps
// Tag keeper of a read-ahead sector buffer: slot valid bits, addresses, byte counts,
// failed marks, a round-robin write pointer and the next sector to fetch.
// Input stream s_axis carries one command per transfer (seek, lookup, release,
// fill, flush); output stream m_axis returns exactly one result per command.
// cfg_we/cfg_index/cfg_wdata write disc_sectors (index 0) and disc_open (index 1);
// write them only while no command is in flight.
// Commands pass a decode register and a two-entry queue, then the executor.
// Executor steps per command: seek and flush pass a commit step, unknown codes go
// straight to the result; lookup and release scan the slots; fill scans for a free slot,
// then commits. The slot scan reads one slot per cycle from the slot memory's single read port.
// A result waits in the output register while m_axis_tready is low; the executor
// stalls only once it has the next result ready, and the queue and the decode register keep
// taking commands until both are full, after which s_axis_tready drops.
// Reset clears all valid bits, the write pointer, the next fetch address, both
// configuration registers and all stream handshake state.
module sector_readahead_slot_manager_top import sra_pkg::*; #(
	parameter int SLOTS        = 8,
	parameter int SECTOR_BYTES = 2352
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// cmd[2:0], sector_addr[26:3], read_bytes[38:27], zero[39]
	input  logic [IN_W-1:0]      s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// hit[0], slot_index[6:1], byte_count[18:7], hit_failed[19], fill_status[22:20],
	// fill_addr[46:23], all_full[47], next_addr[71:48]
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic      push_valid;
	logic      push_ready;
	item_t     push_item;
	logic      pop_valid;
	logic      pop_ready;
	item_t     pop_item;
	disc_cfg_t disc_cfg;

	sra_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item),
		.disc_cfg      (disc_cfg)
	);

	sra_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	sra_back #(
		.SLOTS        (SLOTS),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.disc_cfg      (disc_cfg),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

/* rtl/sra_checker.sv */
`timescale 1ns / 1ps
module sra_checker import sra_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	result_t res;

	assign res = m_axis_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.hit |-> (res.byte_count == '0) && !res.hit_failed)
		else $error("miss carries lookup data");

	a_failed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.hit_failed |-> res.hit && (res.byte_count == '0))
		else $error("failed slot reports bytes");

	a_hit_not_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.hit |-> (res.fill_status == ST_NONE) && (res.fill_addr == '0))
		else $error("lookup hit with fill status");

endmodule

bind sector_readahead_slot_manager_top sra_checker u_sra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
